// File: hw/rtl/cnv_pkg.sv
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared sizes, types and register codes of the 2D convolution block.
// ----------------------------------------------------------------------------
package cnv_pkg;

    localparam int MAX_KERNEL = 7;
    localparam int MAX_IN_CH  = 16;
    localparam int MAX_OUT_CH = 64;
    localparam int MAX_WIDTH  = 256;

    localparam int WEIGHT_DEPTH = MAX_KERNEL * MAX_KERNEL * MAX_IN_CH * MAX_OUT_CH;
    localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH * MAX_IN_CH;
    localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);
    localparam int LINE_AW      = $clog2(LINE_DEPTH);
    localparam int BIAS_AW      = $clog2(MAX_OUT_CH);

    localparam int DIV_W   = 12;
    localparam int DIVS_W  = 5;
    localparam int ACC_W   = 42;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_ACT    = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_KERNEL_HEIGHT = 3'd0,
        REG_KERNEL_WIDTH  = 3'd1,
        REG_STRIDE_ROWS   = 3'd2,
        REG_STRIDE_COLS   = 3'd3,
        REG_IN_CHANNELS   = 3'd4,
        REG_OUT_CHANNELS  = 3'd5,
        REG_IMAGE_WIDTH   = 3'd6,
        REG_IMAGE_HEIGHT  = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BIAS,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

// File: hw/rtl/cnv_in_if.sv
// ----------------------------------------------------------------------------
// cnv_in_if
// Request channel carrying weight, bias and activation items.
// ----------------------------------------------------------------------------
interface cnv_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] index;
    logic signed [15:0] value;

    modport source (output valid, kind, index, value, input ready);
    modport sink   (input valid, kind, index, value, output ready);
endinterface

// File: hw/rtl/cnv_out_if.sv
// ----------------------------------------------------------------------------
// cnv_out_if
// Result channel carrying one convolution output per output channel of a window.
// ----------------------------------------------------------------------------
interface cnv_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] result_value;
    logic [7:0]  out_row;
    logic [7:0]  out_col;
    logic [5:0]  out_channel;
    logic        saturated;
    logic        last_of_window;
    logic        last_of_image;

    modport source (output valid, result_value, out_row, out_col, out_channel,
                    saturated, last_of_window, last_of_image, input ready);
    modport sink   (input valid, result_value, out_row, out_col, out_channel,
                    saturated, last_of_window, last_of_image, output ready);
endinterface

// File: hw/rtl/cnv_ram.sv
// ----------------------------------------------------------------------------
// cnv_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module cnv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/cnv_div.sv
// ----------------------------------------------------------------------------
// cnv_div
// Restoring divider, one quotient bit per cycle, for window grid checks.
// ----------------------------------------------------------------------------
module cnv_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [11:0] dividend,
    input  logic [4:0]  divisor,
    output logic        busy,
    output logic [11:0] quot,
    output logic [4:0]  rem
);
    import cnv_pkg::*;

    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] div_reg;
    logic [3:0]        count_reg, count_next;
    logic [DIVS_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial      = {rem_reg, quot_reg[DIV_W-1]};
        ge         = trial >= {1'b0, div_reg};
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        if (count_reg != 4'd0)
        begin
            quot_next  = {quot_reg[DIV_W-2:0], ge};
            rem_next   = ge ? DIVS_W'(trial - {1'b0, div_reg}) : trial[DIVS_W-1:0];
            count_next = count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 4'd0;
        end
        else if (start)
        begin
            count_reg <= 4'(DIV_W);
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign busy = count_reg != 4'd0;
    assign quot = quot_reg;
    assign rem  = rem_reg;
endmodule

// File: hw/rtl/conv2d_forward_nhwc.sv
// ----------------------------------------------------------------------------
// conv2d_forward_nhwc
// Streaming valid, strided 2D convolution, Q8.8, per-output-channel bias.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel: weight loads (kind 0), bias loads
// (kind 1) and activations (kind 2) in row, column, channel order. Registers
// are set through write_en/reg_index/write_data; the user must set them only
// while the block is idle, which the block itself does not enforce. Items
// are taken only while the block is idle. An activation that is the last
// channel of a pixel at or past the first kernel row and column holds off
// further requests while four dividers test the stride grid. A pixel that
// closes a window then runs, per output channel, one bias read, one
// multiply-accumulate per cycle over kernel_height*kernel_width*in_channels
// taps through the line and weight memories, a pipeline drain and the
// posting of the result.
// Results leave through a single output register; while the receiver stalls
// the accumulator finishes the next channel and then holds.
// Reset clears the pixel counters and restores register defaults; the
// weight, bias and line memories are not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module conv2d_forward_nhwc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        write_en,
    input  logic [2:0]  reg_index,
    input  logic [11:0] write_data,
    cnv_in_if.sink      item,
    cnv_out_if.source   result
);
    import cnv_pkg::*;

    // configuration
    logic [2:0]  kh_reg, kw_reg;
    logic [4:0]  sh_reg, sw_reg, cin_reg;
    logic [6:0]  cout_reg;
    logic [8:0]  wid_reg;
    logic [11:0] hgt_reg;

    logic [2:0]  kh, kw;
    logic [4:0]  sh, sw, cin;
    logic [6:0]  cout;
    logic [8:0]  wid;
    logic [11:0] hgt;

    always_comb
    begin
        kh   = (kh_reg == 3'd0) ? 3'd1 : kh_reg;
        kw   = (kw_reg == 3'd0) ? 3'd1 : kw_reg;
        sh   = (sh_reg == 5'd0) ? 5'd1 : sh_reg;
        sw   = (sw_reg == 5'd0) ? 5'd1 : sw_reg;
        cin  = (cin_reg == 5'd0) ? 5'd1 : ((cin_reg > 5'(MAX_IN_CH)) ? 5'(MAX_IN_CH) : cin_reg);
        cout = (cout_reg == 7'd0) ? 7'd1
             : ((cout_reg > 7'(MAX_OUT_CH)) ? 7'(MAX_OUT_CH) : cout_reg);
        wid  = (wid_reg == 9'd0) ? 9'd1 : ((wid_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : wid_reg);
        hgt  = (hgt_reg == 12'd0) ? 12'd1 : hgt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kh_reg   <= 3'd3;
            kw_reg   <= 3'd3;
            sh_reg   <= 5'd1;
            sw_reg   <= 5'd1;
            cin_reg  <= 5'd1;
            cout_reg <= 7'd1;
            wid_reg  <= 9'd256;
            hgt_reg  <= 12'd256;
        end
        else if (write_en)
        begin
            unique case (reg_index_t'(reg_index))
                REG_KERNEL_HEIGHT: kh_reg   <= write_data[2:0];
                REG_KERNEL_WIDTH:  kw_reg   <= write_data[2:0];
                REG_STRIDE_ROWS:   sh_reg   <= write_data[4:0];
                REG_STRIDE_COLS:   sw_reg   <= write_data[4:0];
                REG_IN_CHANNELS:   cin_reg  <= write_data[4:0];
                REG_OUT_CHANNELS:  cout_reg <= write_data[6:0];
                REG_IMAGE_WIDTH:   wid_reg  <= write_data[8:0];
                REG_IMAGE_HEIGHT:  hgt_reg  <= write_data[11:0];
                default: ;
            endcase
        end
    end

    // control
    state_t state_reg, state_next;

    logic [11:0] row_reg;
    logic [7:0]  col_reg;
    logic [3:0]  ch_reg;
    logic [2:0]  slot_reg;

    logic        accept;
    logic        is_act, ch_last, win_try;
    logic [8:0]  col_inc;

    assign accept  = item.valid && item.ready;
    assign is_act  = kind_t'(item.kind) == KIND_ACT;
    assign ch_last = ({1'b0, ch_reg} + 5'd1) >= cin;
    assign col_inc = {1'b0, col_reg} + 9'd1;
    assign win_try = accept && is_act && ch_last
                     && (row_reg + 12'd1 >= {9'd0, kh}) && (col_inc >= {6'd0, kw});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            ch_reg   <= '0;
            slot_reg <= '0;
        end
        else if (accept && is_act)
        begin
            if (ch_last)
            begin
                ch_reg <= '0;
                if (col_inc >= wid)
                begin
                    col_reg <= '0;
                    if (row_reg + 12'd1 >= hgt)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 12'd1;
                        slot_reg <= (slot_reg == 3'(MAX_KERNEL - 1)) ? 3'd0 : slot_reg + 3'd1;
                    end
                end
                else
                begin
                    col_reg <= col_inc[7:0];
                end
            end
            else
            begin
                ch_reg <= ch_reg + 4'd1;
            end
        end
    end

    // stride grid dividers
    logic        rd_busy, cd_busy, hd_busy, wd_busy;
    logic [11:0] rd_q, cd_q, hd_q, wd_q;
    logic [4:0]  rd_r, cd_r, hd_r, wd_r;
    logic [11:0] cv_ext, wv_ext;
    logic [8:0]  cv9, wv9;

    assign cv9    = col_inc - {6'd0, kw};
    assign wv9    = wid - {6'd0, kw};
    assign cv_ext = {3'd0, cv9};
    assign wv_ext = {3'd0, wv9};

    cnv_div u_div_row (.clk, .rst_n, .start(win_try), .dividend(row_reg + 12'd1 - {9'd0, kh}),
                       .divisor(sh), .busy(rd_busy), .quot(rd_q), .rem(rd_r));
    cnv_div u_div_col (.clk, .rst_n, .start(win_try), .dividend(cv_ext),
                       .divisor(sw), .busy(cd_busy), .quot(cd_q), .rem(cd_r));
    cnv_div u_div_hgt (.clk, .rst_n, .start(win_try), .dividend(hgt - {9'd0, kh}),
                       .divisor(sh), .busy(hd_busy), .quot(hd_q), .rem(hd_r));
    cnv_div u_div_wid (.clk, .rst_n, .start(win_try), .dividend(wv_ext),
                       .divisor(sw), .busy(wd_busy), .quot(wd_q), .rem(wd_r));

    logic div_busy;
    assign div_busy = rd_busy | cd_busy | hd_busy | wd_busy;

    // window bookkeeping, captured at the closing activation and while the dividers run
    logic [2:0]  slot0_reg;
    logic [7:0]  col0_reg;
    logic        fits_reg;
    logic        img_end_reg;
    logic [3:0]  slot_sum;

    assign slot_sum = {1'b0, slot_reg} + 4'(MAX_KERNEL) - {1'b0, kh - 3'd1};

    always_ff @(posedge clk)
    begin
        if (win_try)
        begin
            slot0_reg <= (slot_sum >= 4'(MAX_KERNEL)) ? 3'(slot_sum - 4'(MAX_KERNEL))
                                                     : slot_sum[2:0];
            col0_reg  <= cv9[7:0];
            fits_reg  <= (hgt >= {9'd0, kh}) && (wid >= {6'd0, kw});
        end
        if (state_reg == ST_DIV)
        begin
            img_end_reg <= fits_reg && (rd_q == hd_q) && (cd_q == wd_q);
        end
    end

    // tap sequencer
    logic [5:0]  co_reg, co_next;
    logic [2:0]  kr_reg, kr_next, kc_reg, kc_next;
    logic [3:0]  ci_reg, ci_next;
    logic [2:0]  tslot_reg, tslot_next;
    logic [7:0]  tcol_reg, tcol_next;
    logic [WEIGHT_AW-1:0] wi_reg, wi_next;
    logic        first_reg, first_next;
    logic        issue;
    logic        tap_last;

    // memories
    logic signed [15:0] w_rd, l_rd, b_rd;
    logic        w_we, b_we, l_we;

    assign w_we = accept && kind_t'(item.kind) == KIND_WEIGHT
                  && ({1'b0, item.index} < 17'(WEIGHT_DEPTH));
    assign b_we = accept && kind_t'(item.kind) == KIND_BIAS
                  && ({1'b0, item.index} < 17'(MAX_OUT_CH));
    assign l_we = accept && is_act;

    cnv_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weight (
        .clk, .we(w_we), .waddr(item.index[WEIGHT_AW-1:0]), .wdata(item.value),
        .re(issue), .raddr(wi_reg), .rdata(w_rd));

    cnv_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CH)) u_bias (
        .clk, .we(b_we), .waddr(item.index[BIAS_AW-1:0]), .wdata(item.value),
        .re(state_reg == ST_BIAS), .raddr(co_reg), .rdata(b_rd));

    cnv_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
        .clk, .we(l_we), .waddr({slot_reg, col_reg, ch_reg}), .wdata(item.value),
        .re(issue), .raddr({tslot_reg, tcol_reg, ci_reg}), .rdata(l_rd));

    // multiply-accumulate pipeline
    logic        v1_reg, f1_reg, v2_reg, f2_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg   <= first_reg;
        f2_reg   <= f1_reg;
        prod_reg <= l_rd * w_rd;
        if (v2_reg)
        begin
            acc_reg <= (f2_reg ? (ACC_W'(b_rd) <<< 8) : acc_reg) + ACC_W'(prod_reg);
        end
    end

    // output register
    logic        out_valid_reg;
    logic        load_out;
    logic signed [ACC_W-9:0] q;
    logic        q_hi, q_lo;

    assign q    = acc_reg[ACC_W-1:8];
    assign q_hi = q > (ACC_W-8)'(32767);
    assign q_lo = q < -(ACC_W-8)'(32768);
    assign load_out = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result.result_value   <= q_hi ? 16'sd32767 : (q_lo ? -16'sd32768 : q[15:0]);
            result.saturated      <= q_hi | q_lo;
            result.out_row        <= rd_q[7:0];
            result.out_col        <= cd_q[7:0];
            result.out_channel    <= co_reg;
            result.last_of_window <= ({1'b0, co_reg} + 7'd1) == cout;
            result.last_of_image  <= img_end_reg && (({1'b0, co_reg} + 7'd1) == cout);
        end
    end

    assign result.valid = out_valid_reg;
    assign item.ready   = state_reg == ST_IDLE;

    // sequencer next state
    assign tap_last = (({1'b0, ci_reg} + 5'd1) >= cin) && ((kc_reg + 3'd1) >= kw)
                      && ((kr_reg + 3'd1) >= kh);

    always_comb
    begin
        state_next = state_reg;
        co_next    = co_reg;
        kr_next    = kr_reg;
        kc_next    = kc_reg;
        ci_next    = ci_reg;
        tslot_next = tslot_reg;
        tcol_next  = tcol_reg;
        wi_next    = wi_reg;
        first_next = first_reg;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (win_try)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    co_next    = '0;
                    state_next = (rd_r == 5'd0 && cd_r == 5'd0) ? ST_BIAS : ST_IDLE;
                end
            end
            ST_BIAS:
            begin
                kr_next    = '0;
                kc_next    = '0;
                ci_next    = '0;
                tslot_next = slot0_reg;
                tcol_next  = col0_reg;
                wi_next    = WEIGHT_AW'(co_reg);
                first_next = 1'b1;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                issue      = 1'b1;
                first_next = 1'b0;
                wi_next    = wi_reg + WEIGHT_AW'(cout);
                // advance channel, then column, then kernel row
                if (({1'b0, ci_reg} + 5'd1) >= cin)
                begin
                    ci_next = '0;
                    if ((kc_reg + 3'd1) >= kw)
                    begin
                        kc_next    = '0;
                        tcol_next  = col0_reg;
                        kr_next    = kr_reg + 3'd1;
                        tslot_next = (tslot_reg == 3'(MAX_KERNEL - 1)) ? 3'd0
                                                                      : tslot_reg + 3'd1;
                    end
                    else
                    begin
                        kc_next   = kc_reg + 3'd1;
                        tcol_next = tcol_reg + 8'd1;
                    end
                end
                else
                begin
                    ci_next = ci_reg + 4'd1;
                end
                if (tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    if (({1'b0, co_reg} + 7'd1) >= cout)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        co_next    = co_reg + 6'd1;
                        state_next = ST_BIAS;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        co_reg    <= co_next;
        kr_reg    <= kr_next;
        kc_reg    <= kc_next;
        ci_reg    <= ci_next;
        tslot_reg <= tslot_next;
        tcol_reg  <= tcol_next;
        wi_reg    <= wi_next;
        first_reg <= first_next;
    end

endmodule
